/* rtl/psas_pkg.sv */
// ----------------------------------------------------------------------------
// psas_pkg: shared types and decode for the packed simd add/sub unit
// Operation codes, per-item control struct and the operation decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package psas_pkg;

	localparam int unsigned WordBits = 32;
	localparam int unsigned ByteLanes = WordBits / 8;
	localparam int unsigned HalfLanes = WordBits / 16;

	// operation codes
	typedef enum logic [3:0] {
		OP_ADD16   = 4'd0,
		OP_ADD8    = 4'd1,
		OP_SUB16   = 4'd2,
		OP_SUB8    = 4'd3,
		OP_QADD16  = 4'd4,
		OP_QADD16U = 4'd5,
		OP_QADD8   = 4'd6,
		OP_QADD8U  = 4'd7,
		OP_QSUB16  = 4'd8,
		OP_QSUB16U = 4'd9,
		OP_QSUB8   = 4'd10,
		OP_QSUB8U  = 4'd11
	} op_e;

	// decoded control that travels with each item
	typedef struct packed {
		logic legal;
		logic half;
		logic sgn;
		logic sub;
		logic sat;
	} op_ctl_t;

	// wide lane sums: 8-bit lanes in 10 bits, 16-bit lanes in 18 bits
	typedef logic [ByteLanes-1:0][9:0] sum8_t;
	typedef logic [HalfLanes-1:0][17:0] sum16_t;

	function automatic op_ctl_t decode_op(input logic [3:0] code);
		op_ctl_t c;
		c = '0;
		c.legal = 1'b1;
		unique case (op_e'(code))
			OP_ADD16:   begin c.half = 1'b1; c.sgn = 1'b1; end
			OP_ADD8:    begin c.sgn = 1'b1; end
			OP_SUB16:   begin c.half = 1'b1; c.sgn = 1'b1; c.sub = 1'b1; end
			OP_SUB8:    begin c.sgn = 1'b1; c.sub = 1'b1; end
			OP_QADD16:  begin c.half = 1'b1; c.sgn = 1'b1; c.sat = 1'b1; end
			OP_QADD16U: begin c.half = 1'b1; c.sat = 1'b1; end
			OP_QADD8:   begin c.sgn = 1'b1; c.sat = 1'b1; end
			OP_QADD8U:  begin c.sat = 1'b1; end
			OP_QSUB16:  begin c.half = 1'b1; c.sgn = 1'b1; c.sub = 1'b1; c.sat = 1'b1; end
			OP_QSUB16U: begin c.half = 1'b1; c.sub = 1'b1; c.sat = 1'b1; end
			OP_QSUB8:   begin c.sgn = 1'b1; c.sub = 1'b1; c.sat = 1'b1; end
			OP_QSUB8U:  begin c.sub = 1'b1; c.sat = 1'b1; end
			default:    begin c = '0; end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/psas_lane_arith.sv */
// ----------------------------------------------------------------------------
// psas_lane_arith: per-lane wide add/subtract
// Forms every 8-bit and 16-bit lane sum or difference with guard bits.
// ----------------------------------------------------------------------------
`default_nettype none

module psas_lane_arith
	import psas_pkg::*;
(
	input  var op_ctl_t           ctl,
	input  wire [WordBits-1:0]    a,
	input  wire [WordBits-1:0]    b,
	output sum8_t                 sum8,
	output sum16_t                sum16
);

	// byte lanes, extended by two bits so no value overflows
	always_comb begin
		for (int i = 0; i < ByteLanes; i++) begin
			logic [9:0] ea;
			logic [9:0] eb;
			ea = {{2{ctl.sgn & a[8*i+7]}}, a[8*i +: 8]};
			eb = {{2{ctl.sgn & b[8*i+7]}}, b[8*i +: 8]};
			sum8[i] = ctl.sub ? (ea - eb) : (ea + eb);
		end
	end

	// halfword lanes
	always_comb begin
		for (int j = 0; j < HalfLanes; j++) begin
			logic [17:0] ea;
			logic [17:0] eb;
			ea = {{2{ctl.sgn & a[16*j+15]}}, a[16*j +: 16]};
			eb = {{2{ctl.sgn & b[16*j+15]}}, b[16*j +: 16]};
			sum16[j] = ctl.sub ? (ea - eb) : (ea + eb);
		end
	end

endmodule

`default_nettype wire

/* rtl/psas_sat_pack.sv */
// ----------------------------------------------------------------------------
// psas_sat_pack: lane clamp and result packing
// Clamps each lane sum to its signed or unsigned range when asked, then
// packs the lanes of the selected width into one word.
// ----------------------------------------------------------------------------
`default_nettype none

module psas_sat_pack
	import psas_pkg::*;
(
	input  var op_ctl_t           ctl,
	input  var sum8_t             sum8,
	input  var sum16_t            sum16,
	output logic [WordBits-1:0]   result
);

	logic [WordBits-1:0] res8;
	logic [WordBits-1:0] res16;

	// clamp byte lanes
	always_comb begin
		for (int i = 0; i < ByteLanes; i++) begin
			logic signed [9:0] r;
			r = $signed(sum8[i]);
			res8[8*i +: 8] = r[7:0];
			if (ctl.sat) begin
				if (ctl.sgn) begin
					if (r > 10'sd127)
						res8[8*i +: 8] = 8'h7f;
					else if (r < -10'sd128)
						res8[8*i +: 8] = 8'h80;
				end else begin
					if (r > 10'sd255)
						res8[8*i +: 8] = 8'hff;
					else if (r < 10'sd0)
						res8[8*i +: 8] = 8'h00;
				end
			end
		end
	end

	// clamp halfword lanes
	always_comb begin
		for (int j = 0; j < HalfLanes; j++) begin
			logic signed [17:0] r;
			r = $signed(sum16[j]);
			res16[16*j +: 16] = r[15:0];
			if (ctl.sat) begin
				if (ctl.sgn) begin
					if (r > 18'sd32767)
						res16[16*j +: 16] = 16'h7fff;
					else if (r < -18'sd32768)
						res16[16*j +: 16] = 16'h8000;
				end else begin
					if (r > 18'sd65535)
						res16[16*j +: 16] = 16'hffff;
					else if (r < 18'sd0)
						res16[16*j +: 16] = 16'h0000;
				end
			end
		end
	end

	// lane width select, unused codes give zero
	always_comb begin
		if (!ctl.legal)
			result = '0;
		else if (ctl.half)
			result = res16;
		else
			result = res8;
	end

endmodule

`default_nettype wire

/* rtl/packed_simd_add_sub_unit.sv */
// ----------------------------------------------------------------------------
// packed_simd_add_sub_unit: packed simd add/subtract, 8- and 16-bit lanes
// Throughput: one item per cycle while the output is not stalled; each stage
// holds while the one after it is full and stalled, so the three stage
// registers set the depth.
// Reset: arst_n clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_simd_add_sub_unit
	import psas_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire [3:0]            operation,
	input  wire [WordBits-1:0]   operand_a,
	input  wire [WordBits-1:0]   operand_b,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [WordBits-1:0]  packed_result
);

	logic                valid_s1, valid_s2, valid_s3;
	logic                en_s1, en_s2, en_s3;
	op_ctl_t             ctl_s1, ctl_s2;
	logic [WordBits-1:0] a_s1, b_s1;
	sum8_t               sum8_s2;
	sum16_t              sum16_s2;
	logic [WordBits-1:0] result_s3;
	sum8_t               sum8;
	sum16_t              sum16;
	logic [WordBits-1:0] result;

	// stage enables: a stage loads when empty or when its content moves on
	assign en_s3 = !valid_s3 || out_ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= in_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_s3)
				valid_s3 <= valid_s2;
		end
	end

	// stage 1: decode and capture operands
	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctl_s1 <= decode_op(operation);
			a_s1   <= operand_a;
			b_s1   <= operand_b;
		end
	end

	psas_lane_arith u_arith (
		.ctl   (ctl_s1),
		.a     (a_s1),
		.b     (b_s1),
		.sum8  (sum8),
		.sum16 (sum16)
	);

	// stage 2: wide lane sums
	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctl_s2   <= ctl_s1;
			sum8_s2  <= sum8;
			sum16_s2 <= sum16;
		end
	end

	psas_sat_pack u_sat (
		.ctl    (ctl_s2),
		.sum8   (sum8_s2),
		.sum16  (sum16_s2),
		.result (result)
	);

	// stage 3: packed result, doubles as output register
	always_ff @(posedge clk) begin
		if (en_s3)
			result_s3 <= result;
	end

	assign out_valid     = valid_s3;
	assign packed_result = result_s3;

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the packed simd add/sub unit
// A short table of hand-picked operands (lane extremes, every operation and
// the first and last unused codes) comes first. Random packed words with lane-edge values
// follow. Both handshake sides idle at random. Every result transfer is
// checked against a lane-by-lane model, or against the typed table value.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psas_pkg::*;

	localparam int NUM_RANDOM = 700;
	localparam int MAX_SHOWN = 10;
	localparam int TAIL_CYCLES = 8;

	// codes with no operation behind them
	localparam logic [3:0] OP_RSVD_FIRST = 4'd12;
	localparam logic [3:0] OP_RSVD_LAST  = 4'd15;

	// one directed row: operands plus an optional typed result
	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic        typed;
		logic [31:0] result;
	} dir_row_t;

	// one transfer in flight and the word it must produce
	typedef struct {
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] result;
	} lane_job_t;

	localparam int NUM_DIR = 24;

	dir_row_t dir_rows [NUM_DIR] = '{
		// wrapping at the lane edges
		'{OP_ADD16,   32'hFFFF_FFFF, 32'h0001_0001, 1'b1, 32'h0000_0000},
		'{OP_ADD8,    32'hFFFF_FFFF, 32'h0101_0101, 1'b1, 32'h0000_0000},
		'{OP_SUB16,   32'h0000_0000, 32'h0001_0001, 1'b1, 32'hFFFF_FFFF},
		'{OP_SUB8,    32'h0000_0000, 32'h0101_0101, 1'b1, 32'hFFFF_FFFF},
		'{OP_ADD16,   32'h7FFF_8000, 32'h0001_FFFF, 1'b0, 32'h0},
		'{OP_SUB8,    32'h807F_00FF, 32'h01FF_8001, 1'b0, 32'h0},
		// signed clamps
		'{OP_QADD16,  32'h7FFF_7FFF, 32'h0001_0001, 1'b1, 32'h7FFF_7FFF},
		'{OP_QADD16,  32'h8000_8000, 32'h8000_8000, 1'b1, 32'h8000_8000},
		'{OP_QSUB16,  32'h8000_8000, 32'h0001_0001, 1'b1, 32'h8000_8000},
		'{OP_QSUB16,  32'h7FFF_8000, 32'h8000_7FFF, 1'b1, 32'h7FFF_8000},
		'{OP_QADD8,   32'h7F7F_7F7F, 32'h0101_0101, 1'b1, 32'h7F7F_7F7F},
		'{OP_QADD8,   32'h8080_8080, 32'h8080_8080, 1'b1, 32'h8080_8080},
		'{OP_QSUB8,   32'h8080_8080, 32'h0101_0101, 1'b1, 32'h8080_8080},
		'{OP_QSUB8,   32'h7F7F_7F7F, 32'h8080_8080, 1'b1, 32'h7F7F_7F7F},
		// unsigned clamps
		'{OP_QADD16U, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{OP_QSUB16U, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{OP_QADD8U,  32'hFFFF_FFFF, 32'h0101_0101, 1'b1, 32'hFFFF_FFFF},
		'{OP_QSUB8U,  32'h0000_0000, 32'h0101_0101, 1'b1, 32'h0000_0000},
		// mixed lanes: some clamp, some do not
		'{OP_QADD8,   32'h7F80_017F, 32'h017F_FF80, 1'b0, 32'h0},
		'{OP_QSUB8U,  32'hFF10_0180, 32'h0020_FF7F, 1'b0, 32'h0},
		'{OP_QADD16U, 32'h1234_FFFE, 32'h4321_0001, 1'b0, 32'h0},
		'{OP_QSUB16U, 32'h8000_0001, 32'h7FFF_0002, 1'b0, 32'h0},
		// unused codes give zero
		'{OP_RSVD_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{OP_RSVD_LAST,  32'h8765_4321, 32'h1234_5678, 1'b1, 32'h0000_0000}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  operation = OP_ADD16;
	logic [31:0] operand_a = '0;
	logic [31:0] operand_b = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] packed_result;

	lane_job_t   lane_jobs_q [$];
	int          mismatch_count = 0;
	int          sent_count = 0;
	int          got_count = 0;

	packed_simd_add_sub_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packed_result (packed_result)
	);

	// clock
	always #6 clk = ~clk;

	// lane-by-lane add/subtract with optional clamp
	function automatic logic [31:0] lane_arith(logic [3:0] code, logic [31:0] a,
			logic [31:0] b);
		int unsigned w;
		int unsigned mask;
		bit          sgn;
		bit          sub;
		bit          sat;
		int          va;
		int          vb;
		int          r;
		int          hi;
		int          lo;
		logic [31:0] res;
		w = 0;
		sgn = 1'b0;
		sub = 1'b0;
		sat = 1'b0;
		res = '0;
		case (code)
			OP_ADD16:   begin w = 16; sgn = 1'b1; end
			OP_ADD8:    begin w = 8; sgn = 1'b1; end
			OP_SUB16:   begin w = 16; sgn = 1'b1; sub = 1'b1; end
			OP_SUB8:    begin w = 8; sgn = 1'b1; sub = 1'b1; end
			OP_QADD16:  begin w = 16; sgn = 1'b1; sat = 1'b1; end
			OP_QADD16U: begin w = 16; sat = 1'b1; end
			OP_QADD8:   begin w = 8; sgn = 1'b1; sat = 1'b1; end
			OP_QADD8U:  begin w = 8; sat = 1'b1; end
			OP_QSUB16:  begin w = 16; sgn = 1'b1; sub = 1'b1; sat = 1'b1; end
			OP_QSUB16U: begin w = 16; sub = 1'b1; sat = 1'b1; end
			OP_QSUB8:   begin w = 8; sgn = 1'b1; sub = 1'b1; sat = 1'b1; end
			OP_QSUB8U:  begin w = 8; sub = 1'b1; sat = 1'b1; end
			default:    w = 0;
		endcase
		if (w != 0) begin
			mask = (32'd1 << w) - 1;
			hi = sgn ? int'((32'd1 << (w - 1)) - 1) : int'(mask);
			lo = sgn ? -int'(32'd1 << (w - 1)) : 0;
			for (int i = 0; i < int'(32 / w); i++) begin
				va = int'((a >> (i * w)) & mask);
				vb = int'((b >> (i * w)) & mask);
				// sign-extend the lane for signed operations
				if (sgn && va >= int'(32'd1 << (w - 1)))
					va = va - int'(32'd1 << w);
				if (sgn && vb >= int'(32'd1 << (w - 1)))
					vb = vb - int'(32'd1 << w);
				r = sub ? va - vb : va + vb;
				if (sat) begin
					if (r > hi)
						r = hi;
					else if (r < lo)
						r = lo;
				end
				res = res | ((32'(r) & mask) << (i * w));
			end
		end
		return res;
	endfunction

	// idle length: runs with no gaps, then mostly gaps
	function automatic int draw_gap(int n);
		if ((n % 64) < 16)
			return 0;
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(1, 18);
	endfunction

	// packed word with lanes drawn around the clamp points
	function automatic logic [31:0] draw_word();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(0, 3))
			1: begin
				for (int i = 0; i < 4; i++)
					case ($urandom_range(0, 5))
						0: w[i*8 +: 8] = 8'h00;
						1: w[i*8 +: 8] = 8'h01;
						2: w[i*8 +: 8] = 8'h7F;
						3: w[i*8 +: 8] = 8'h80;
						4: w[i*8 +: 8] = 8'hFF;
						default: ;
					endcase
			end
			2: begin
				for (int i = 0; i < 2; i++)
					case ($urandom_range(0, 5))
						0: w[i*16 +: 16] = 16'h0000;
						1: w[i*16 +: 16] = 16'h0001;
						2: w[i*16 +: 16] = 16'h7FFF;
						3: w[i*16 +: 16] = 16'h8000;
						4: w[i*16 +: 16] = 16'hFFFF;
						default: ;
					endcase
			end
			default: ;
		endcase
		return w;
	endfunction

	// drive one item and hold it until the transfer
	task automatic send_item(logic [3:0] op, logic [31:0] a, logic [31:0] b,
			logic typed, logic [31:0] typed_result);
		int        gap;
		lane_job_t job;
		gap = draw_gap(sent_count);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		job.op = op;
		job.a = a;
		job.b = b;
		job.result = typed ? typed_result : lane_arith(op, a, b);
		lane_jobs_q.push_back(job);
		sent_count++;
	endtask

	// result side: random stalls, compare each transfer in order
	initial begin
		lane_job_t job;
		int        gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(got_count + 32);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			got_count++;
			if (lane_jobs_q.size() == 0) begin
				if (mismatch_count < MAX_SHOWN)
					$display("unexpected result %h", packed_result);
				mismatch_count++;
			end else begin
				job = lane_jobs_q.pop_front();
				if (packed_result !== job.result) begin
					if (mismatch_count < MAX_SHOWN)
						$display("mismatch op %0d a %h b %h: expected %h, got %h",
							job.op, job.a, job.b, job.result, packed_result);
					mismatch_count++;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [3:0] op;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < NUM_DIR; i++)
			send_item(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b,
				dir_rows[i].typed, dir_rows[i].result);

		// random words, now and then an unused code
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if ($urandom_range(0, 9) == 0)
				op = 4'($urandom_range(0, 15));
			else
				op = 4'($urandom_range(0, 11));
			send_item(op, draw_word(), draw_word(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		// drain, then let a stray result show up
		while (lane_jobs_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && lane_jobs_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/psas_pkg.sv
rtl/psas_lane_arith.sv
rtl/psas_sat_pack.sv
rtl/packed_simd_add_sub_unit.sv
tb/tb.sv
